// ----- src/u8idx_pkg.sv -----
// Shared widths, status codes and lead byte masks for the indexed UTF-8 decoder.
package u8idx_pkg;

   localparam int ByteWidth  = 8;
   localparam int IndexWidth = 32;
   localparam int PointWidth = 21;
   localparam int StatusWidth = 2;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [IndexWidth-1:0]  index_type;
   typedef logic [PointWidth-1:0]  point_type;
   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type StFound   = 2'd0;
   localparam status_type StBadLead = 2'd1;
   localparam status_type StBadCont = 2'd2;
   localparam status_type StRange   = 2'd3;

   // lead byte sorting masks and patterns
   localparam byte_type AsciiMask  = 8'h80;
   localparam byte_type Lead2Mask  = 8'hE0;
   localparam byte_type Lead2Tag   = 8'hC0;
   localparam byte_type Lead2Bits  = 8'h1F;
   localparam byte_type Lead3Mask  = 8'hF0;
   localparam byte_type Lead3Tag   = 8'hE0;
   localparam byte_type Lead3Bits  = 8'h0F;
   localparam byte_type Lead4Mask  = 8'hF8;
   localparam byte_type Lead4Tag   = 8'hF0;
   localparam byte_type Lead4Bits  = 8'h07;
   localparam byte_type ContMask   = 8'hC0;
   localparam byte_type ContTag    = 8'h80;
   localparam byte_type ContBits   = 8'h3F;

endpackage

// ----- src/u8idx_channels.sv -----
// Valid/ready channel interfaces for the request bytes and the decode responses.
interface u8idx_req_if;
   logic                  valid;
   logic                  ready;
   u8idx_pkg::byte_type   data_byte;
   u8idx_pkg::index_type  target_index;

   modport source (output valid, output data_byte, output target_index, input ready);
   modport sink   (input valid, input data_byte, input target_index, output ready);
endinterface

interface u8idx_rsp_if;
   logic                   valid;
   logic                   ready;
   u8idx_pkg::point_type   unicode_value;
   u8idx_pkg::status_type  status;

   modport source (output valid, output unicode_value, output status, input ready);
   modport sink   (input valid, input unicode_value, input status, output ready);
endinterface

// ----- src/utf8_indexed_code_point_decoder_top.sv -----
// Indexed UTF-8 code point decoder: byte stream in, one decode response per string out.
//
// Usage
//   req_ch carries one string byte per beat (data_byte) plus target_index, which is
//   sampled only with the first byte of each string. A zero byte ends the string.
//   rsp_ch carries at most one beat per string: unicode_value and status
//   (found, bad lead byte, bad continuation, index out of range). unicode_value is
//   zero unless the status is found.
// Pipeline and throughput
//   A byte is taken into the input register when accepted and resolved into the
//   response register when it advances; it waits in the input register while an
//   untaken response still holds the response register.
//   One byte per cycle is sustained while rsp_ch takes responses: the scan state is
//   a small update done in one pass between the two registers.
// Reset
//   Synchronous reset empties both registers and rearms the scanner: the next byte
//   is treated as the first of a string and the character count starts at zero.
// Stalls
//   While a response waits on rsp_ch, hold it in the response register and hold the
//   next byte in the input register; req_ch.ready drops while that byte is held.
//   Taking the response frees both registers at the same edge.
module utf8_indexed_code_point_decoder_top (
   input logic        clock,
   input logic        reset,
   u8idx_req_if.sink  req_ch,
   u8idx_rsp_if.source rsp_ch
);

   // scan phases
   localparam logic [1:0] PhScan   = 2'd0;
   localparam logic [1:0] PhSkip   = 2'd1;
   localparam logic [1:0] PhDecode = 2'd2;
   localparam logic [1:0] PhDone   = 2'd3;

   // input register
   logic                 in_valid_ff, in_valid_in;
   u8idx_pkg::byte_type  in_byte_ff;
   u8idx_pkg::index_type in_target_ff;

   // scan state
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           bytes_left_ff, bytes_left_in;
   u8idx_pkg::index_type char_counter_ff, char_counter_in;
   u8idx_pkg::point_type partial_ff, partial_in;
   u8idx_pkg::index_type wanted_ff, wanted_in;
   logic                 start_ff, start_in;

   // response register
   logic                  out_valid_ff, out_valid_in;
   u8idx_pkg::point_type  out_point_ff, out_point_in;
   u8idx_pkg::status_type out_status_ff, out_status_in;

   logic                 advance;
   logic                 accept;
   logic                 emit;
   u8idx_pkg::point_type emit_point;
   u8idx_pkg::status_type emit_status;
   u8idx_pkg::index_type wanted_now;
   logic [2:0]           lead_len;
   u8idx_pkg::point_type lead_bits;
   logic                 lead_ok;
   u8idx_pkg::point_type cont_point;

   // Advance the held byte once the response register is free or being drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign accept        = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.unicode_value = out_point_ff;
   assign rsp_ch.status        = out_status_ff;

   // The first byte of a string brings its own target.
   assign wanted_now = start_ff ? in_target_ff : wanted_ff;

   // Sort the lead byte by its high bits.
   always_comb begin
      lead_ok   = 1'b1;
      lead_len  = 3'd1;
      lead_bits = u8idx_pkg::PointWidth'(in_byte_ff);
      priority if ((in_byte_ff & u8idx_pkg::AsciiMask) == '0) begin
         lead_len  = 3'd1;
         lead_bits = u8idx_pkg::PointWidth'(in_byte_ff);
      end else if ((in_byte_ff & u8idx_pkg::Lead2Mask) == u8idx_pkg::Lead2Tag) begin
         lead_len  = 3'd2;
         lead_bits = u8idx_pkg::PointWidth'(in_byte_ff & u8idx_pkg::Lead2Bits);
      end else if ((in_byte_ff & u8idx_pkg::Lead3Mask) == u8idx_pkg::Lead3Tag) begin
         lead_len  = 3'd3;
         lead_bits = u8idx_pkg::PointWidth'(in_byte_ff & u8idx_pkg::Lead3Bits);
      end else if ((in_byte_ff & u8idx_pkg::Lead4Mask) == u8idx_pkg::Lead4Tag) begin
         lead_len  = 3'd4;
         lead_bits = u8idx_pkg::PointWidth'(in_byte_ff & u8idx_pkg::Lead4Bits);
      end else begin
         lead_ok = 1'b0;
      end
   end

   // Shift six more payload bits into the point being built.
   assign cont_point = {partial_ff[u8idx_pkg::PointWidth-7:0],
                        in_byte_ff[5:0] & u8idx_pkg::ContBits[5:0]};

   // One pass of the scanner over the held byte.
   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      char_counter_in = char_counter_ff;
      partial_in      = partial_ff;
      wanted_in       = wanted_ff;
      start_in        = start_ff;
      emit            = 1'b0;
      emit_point      = '0;
      emit_status     = u8idx_pkg::StFound;

      if (advance) begin
         wanted_in = wanted_now;
         start_in  = 1'b0;
         if (in_byte_ff == '0) begin
            // End of string: rearm, and report unless a result was already given.
            phase_in        = PhScan;
            bytes_left_in   = '0;
            char_counter_in = '0;
            partial_in      = '0;
            start_in        = 1'b1;
            emit            = (phase_ff != PhDone);
            emit_status     = (phase_ff == PhDecode) ? u8idx_pkg::StBadCont
                                                     : u8idx_pkg::StRange;
         end else begin
            unique case (phase_ff)
               PhScan: begin
                  if (!lead_ok) begin
                     phase_in    = PhDone;
                     emit        = 1'b1;
                     emit_status = u8idx_pkg::StBadLead;
                  end else if (char_counter_ff == wanted_now) begin
                     if (lead_len == 3'd1) begin
                        phase_in   = PhDone;
                        emit       = 1'b1;
                        emit_point = lead_bits;
                     end else begin
                        partial_in    = lead_bits;
                        bytes_left_in = 2'(lead_len - 3'd1);
                        phase_in      = PhDecode;
                     end
                  end else begin
                     char_counter_in = char_counter_ff + u8idx_pkg::index_type'(1);
                     if (lead_len != 3'd1) begin
                        bytes_left_in = 2'(lead_len - 3'd1);
                        phase_in      = PhSkip;
                     end
                  end
               end
               PhSkip: begin
                  // Drop trailing bytes of a passed character unchecked.
                  bytes_left_in = bytes_left_ff - 2'd1;
                  if (bytes_left_ff == 2'd1) begin
                     phase_in = PhScan;
                  end
               end
               PhDecode: begin
                  if ((in_byte_ff & u8idx_pkg::ContMask) != u8idx_pkg::ContTag) begin
                     phase_in    = PhDone;
                     partial_in  = '0;
                     emit        = 1'b1;
                     emit_status = u8idx_pkg::StBadCont;
                  end else begin
                     partial_in    = cont_point;
                     bytes_left_in = bytes_left_ff - 2'd1;
                     if (bytes_left_ff == 2'd1) begin
                        phase_in   = PhDone;
                        emit       = 1'b1;
                        emit_point = cont_point;
                     end
                  end
               end
               PhDone: begin
                  // Ignore bytes until the terminator.
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Load the response register on a new result; clear it once taken.
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_point_in  = out_point_ff;
      out_status_in = out_status_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_point_in  = emit_point;
         out_status_in = emit_status;
      end
   end

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PhScan;
         bytes_left_ff   <= '0;
         char_counter_ff <= '0;
         partial_ff      <= '0;
         wanted_ff       <= '0;
         start_ff        <= 1'b1;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         char_counter_ff <= char_counter_in;
         partial_ff      <= partial_in;
         wanted_ff       <= wanted_in;
         start_ff        <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff   <= req_ch.data_byte;
         in_target_ff <= req_ch.target_index;
      end
      out_point_ff  <= out_point_in;
      out_status_ff <= out_status_in;
   end

   // A character in flight always has trailing bytes outstanding.
   a_skip_pending: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhSkip || phase_ff == PhDecode) |-> bytes_left_ff != 2'd0)
      else $error("skip or decode phase with no trailing bytes left");

   // Only a found response carries a code point.
   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != u8idx_pkg::StFound) |-> out_point_ff == '0)
      else $error("non-found response with a code point");

   // A terminator rearms the scanner.
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff == '0) |=> (start_ff && phase_ff == PhScan
                                        && char_counter_ff == '0))
      else $error("terminator did not rearm the scanner");

   // A new result never lands on a waiting one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && out_valid_ff) |-> rsp_ch.ready)
      else $error("response overwritten before it was taken");

endmodule

// ----- tb/sv/utf8_indexed_code_point_decoder_top_test.sv -----
// Self-checking testbench for the indexed UTF-8 code point decoder.
`timescale 1ns / 100ps

module utf8_indexed_code_point_decoder_top_test;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 11;
   localparam int RandomBytes = 925;     // random beats after the directed part
   localparam int QuietLimit  = 2000;    // cycles with no beat on either channel
   localparam int DrainCycles = 8;       // extra cycles after the last answer is in
   localparam logic [7:0] StallPattern = 8'b1100_1010;

   // Scan phases of the decoder, as the predictor tracks them.
   localparam logic [1:0] PhScan   = 2'd0;
   localparam logic [1:0] PhSkip   = 2'd1;
   localparam logic [1:0] PhDecode = 2'd2;
   localparam logic [1:0] PhDone   = 2'd3;

   typedef struct packed {
      u8idx_pkg::point_type  unicode_value;
      u8idx_pkg::status_type status;
   } answer_type;

   // Tracks the decode state, predicts the one answer per string and checks
   // each response beat against the oldest outstanding answer.
   class char_tracker;
      answer_type           awaited_points[$];
      logic [1:0]           phase;
      logic [1:0]           bytes_left;
      u8idx_pkg::index_type char_count;
      u8idx_pkg::index_type wanted;
      u8idx_pkg::point_type partial;
      bit                   at_start;
      int unsigned          mismatch_count;

      function new();
         rearm();
         wanted = '0;
         mismatch_count = 0;
      endfunction

      function void rearm();
         phase = PhScan;
         bytes_left = '0;
         char_count = '0;
         partial = '0;
         at_start = 1'b1;
      endfunction

      function void await_answer(u8idx_pkg::point_type cp, u8idx_pkg::status_type st);
         answer_type a;
         a.unicode_value = cp;
         a.status = st;
         awaited_points.push_back(a);
      endfunction

      function void decode_byte(u8idx_pkg::byte_type b, u8idx_pkg::index_type idx_in);
         int unsigned          seq_len;
         u8idx_pkg::point_type lead_bits;
         logic [1:0]           was;
         if (at_start) begin
            wanted = idx_in;
            at_start = 1'b0;
         end
         if (b == '0) begin
            was = phase;
            rearm();
            if (was == PhDecode) await_answer('0, u8idx_pkg::StBadCont);
            else if (was != PhDone) await_answer('0, u8idx_pkg::StRange);
            return;
         end
         case (phase)
            PhScan: begin
               if ((b & u8idx_pkg::AsciiMask) == '0) begin
                  seq_len = 1;
                  lead_bits = u8idx_pkg::point_type'(b);
               end else if ((b & u8idx_pkg::Lead2Mask) == u8idx_pkg::Lead2Tag) begin
                  seq_len = 2;
                  lead_bits = u8idx_pkg::point_type'(b & u8idx_pkg::Lead2Bits);
               end else if ((b & u8idx_pkg::Lead3Mask) == u8idx_pkg::Lead3Tag) begin
                  seq_len = 3;
                  lead_bits = u8idx_pkg::point_type'(b & u8idx_pkg::Lead3Bits);
               end else if ((b & u8idx_pkg::Lead4Mask) == u8idx_pkg::Lead4Tag) begin
                  seq_len = 4;
                  lead_bits = u8idx_pkg::point_type'(b & u8idx_pkg::Lead4Bits);
               end else begin
                  phase = PhDone;
                  await_answer('0, u8idx_pkg::StBadLead);
                  return;
               end
               if (char_count == wanted) begin
                  if (seq_len == 1) begin
                     phase = PhDone;
                     await_answer(lead_bits, u8idx_pkg::StFound);
                  end else begin
                     partial = lead_bits;
                     bytes_left = 2'(seq_len - 1);
                     phase = PhDecode;
                  end
                  return;
               end
               char_count++;
               if (seq_len > 1) begin
                  bytes_left = 2'(seq_len - 1);
                  phase = PhSkip;
               end
            end
            PhSkip: begin
               bytes_left--;
               if (bytes_left == '0) phase = PhScan;
            end
            PhDecode: begin
               if ((b & u8idx_pkg::ContMask) != u8idx_pkg::ContTag) begin
                  phase = PhDone;
                  partial = '0;
                  await_answer('0, u8idx_pkg::StBadCont);
               end else begin
                  partial = (partial << 6) | u8idx_pkg::point_type'(b & u8idx_pkg::ContBits);
                  bytes_left--;
                  if (bytes_left == '0) begin
                     phase = PhDone;
                     await_answer(partial, u8idx_pkg::StFound);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_response(u8idx_pkg::point_type cp, u8idx_pkg::status_type st);
         answer_type a;
         if (awaited_points.size() == 0) begin
            report_mismatch($sformatf("unexpected response cp=%h st=%0d", cp, st));
         end else begin
            a = awaited_points.pop_front();
            if (cp !== a.unicode_value)
               report_mismatch($sformatf("unicode_value %h, want %h", cp, a.unicode_value));
            if (st !== a.status)
               report_mismatch($sformatf("status %0d, want %0d", st, a.status));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8idx_req_if req_ch();
   u8idx_rsp_if rsp_ch();

   utf8_indexed_code_point_decoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   char_tracker              tracker;
   u8idx_pkg::byte_type      text_bytes[$];
   int unsigned              bytes_sent  = 0;
   int unsigned              burst_left  = 0;
   int unsigned              quiet_cycles = 0;
   logic [8:0]               stall_tick  = '0;

   always #(ClockPeriod / 2) clock = ~clock;

   // Receiver: cycle through free running, mostly ready, mostly stalled and a
   // fixed stall pattern, so back-pressure lands on every phase of the scan.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 9'd1;
      case (stall_tick[8:7])
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= StallPattern[stall_tick[2:0]];
      endcase
   end

   // Monitor both channels on the same edge; pre-edge values are what the
   // block saw, so the order against the drivers does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.unicode_value, rsp_ch.status);
         if (req_ch.valid && req_ch.ready)
            tracker.decode_byte(req_ch.data_byte, req_ch.target_index);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         // Stop a hung run: nothing has moved for far longer than any gap or stall.
         if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Drive one byte. The sender runs in bursts; between bursts drop valid for
   // a random gap, and now and then run a long burst with no gap at all.
   task send_byte(u8idx_pkg::byte_type b, u8idx_pkg::index_type idx);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.target_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      bytes_sent++;
   endtask

   // Send the assembled text. Only the first beat's index counts; fill the
   // rest with noise so the block must ignore it.
   task send_text(u8idx_pkg::index_type target);
      for (int i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], (i == 0) ? target : u8idx_pkg::index_type'($urandom()));
   endtask

   // Hold the sender until every outstanding answer has come back. Sample the
   // tracker on the falling edge, then realign to a rising edge.
   task wait_answers_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (tracker.awaited_points.size() != 0);
      @(posedge clock);
   endtask

   // Append one well-formed character with random payload bits.
   function void add_char(int unsigned seq_len);
      case (seq_len)
         1: text_bytes.push_back(u8idx_pkg::byte_type'($urandom_range(1, 127)));
         2: text_bytes.push_back(u8idx_pkg::Lead2Tag
                                 | u8idx_pkg::byte_type'($urandom_range(0, 31)));
         3: text_bytes.push_back(u8idx_pkg::Lead3Tag
                                 | u8idx_pkg::byte_type'($urandom_range(0, 15)));
         default: text_bytes.push_back(u8idx_pkg::Lead4Tag
                                       | u8idx_pkg::byte_type'($urandom_range(0, 7)));
      endcase
      for (int i = 1; i < seq_len; i++)
         text_bytes.push_back(u8idx_pkg::ContTag
                              | u8idx_pkg::byte_type'($urandom_range(0, 63)));
   endfunction

   // Build and send one random string. Most are well formed; the rest carry a
   // bad lead byte, a bad continuation byte, a truncated character or noise.
   task send_random_string();
      int unsigned          n_chars;
      int unsigned          kind;
      int unsigned          fault_at;
      int unsigned          seq_len;
      int unsigned          pick;
      bit                   cut;
      u8idx_pkg::index_type target;
      text_bytes.delete();
      n_chars  = $urandom_range(0, 8);
      kind     = $urandom_range(0, 9);
      fault_at = $urandom_range(0, n_chars);
      cut      = 1'b0;
      if (kind == 9) begin
         repeat ($urandom_range(0, 10))
            text_bytes.push_back(u8idx_pkg::byte_type'($urandom_range(1, 255)));
      end else begin
         for (int unsigned i = 0; i <= n_chars && !cut; i++) begin
            if (kind >= 6 && i == fault_at) begin
               case (kind)
                  6: text_bytes.push_back($urandom_range(0, 1)
                        ? u8idx_pkg::byte_type'($urandom_range(8'h80, 8'hBF))
                        : u8idx_pkg::byte_type'($urandom_range(8'hF8, 8'hFF)));
                  7: begin
                     // good lead, then a non-continuation byte somewhere inside
                     seq_len = $urandom_range(2, 4);
                     add_char(seq_len);
                     pick = $urandom_range(1, seq_len - 1);
                     text_bytes[text_bytes.size() - seq_len + pick] =
                        $urandom_range(0, 1)
                        ? u8idx_pkg::byte_type'($urandom_range(8'h01, 8'h7F))
                        : u8idx_pkg::byte_type'($urandom_range(8'hC0, 8'hFF));
                  end
                  default: begin
                     // lead and too few continuation bytes, then the zero
                     seq_len = $urandom_range(2, 4);
                     add_char(seq_len);
                     repeat ($urandom_range(1, seq_len - 1)) void'(text_bytes.pop_back());
                     cut = 1'b1;
                  end
               endcase
            end
            if (i < n_chars && !cut) add_char($urandom_range(1, 4));
         end
      end
      text_bytes.push_back('0);
      pick = $urandom_range(0, 9);
      if (pick <= 6)      target = u8idx_pkg::index_type'($urandom_range(0, n_chars + 1));
      else if (pick == 7) target = u8idx_pkg::index_type'(n_chars + $urandom_range(0, 3));
      else if (pick == 8) target = u8idx_pkg::index_type'($urandom());
      else                target = '1;
      send_text(target);
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      tracker = new();
      req_ch.valid        <= 1'b0;
      req_ch.data_byte    <= '0;
      req_ch.target_index <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // empty string: zero while scanning, index out of range
      text_bytes = '{8'h00};                            send_text('0);
      // largest single byte character
      text_bytes = '{8'h7F, 8'h00};                     send_text('0);
      // skip a two byte character, then find an ASCII one
      text_bytes = '{8'hC2, 8'h80, 8'h41, 8'h00};       send_text(u8idx_pkg::index_type'(1));
      // every payload bit set in a four byte character
      text_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00}; send_text('0);
      // bad lead byte of the 11111xxx form, with the largest index
      text_bytes = '{8'hFF, 8'h00};                     send_text('1);
      // bad continuation, then the zero after the answer only rearms
      text_bytes = '{8'hE0, 8'h41, 8'h00};              send_text('0);
      // zero inside the wanted character
      text_bytes = '{8'hF0, 8'h80, 8'h00};              send_text('0);
      // zero inside a skipped character ends the string
      text_bytes = '{8'hE2, 8'h00};                     send_text(u8idx_pkg::index_type'(5));
      // stray continuation byte as a lead, before the wanted character
      text_bytes = '{8'h80, 8'h00};                     send_text(u8idx_pkg::index_type'(3));

      // Random part; halfway through, hold the sender until all answers are in.
      bytes_sent = 0;
      while (bytes_sent < RandomBytes) begin
         if (!paused && bytes_sent >= RandomBytes / 2) begin
            wait_answers_drained();
            paused = 1'b1;
         end
         send_random_string();
      end

      wait_answers_drained();
      repeat (DrainCycles) @(posedge clock);
      if (tracker.mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
